FILE: src/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Character constants, token kinds, scanning modes and character classes.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_I       = 8'h69;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_PIPE    = 8'h7C;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// Largest number of results that one request can cause.
	localparam int MAX_RES = 4;

	typedef enum logic [2:0] {
		KIND_STRING = 3'd0,
		KIND_OPER   = 3'd1,
		KIND_WORD   = 3'd2,
		KIND_EOL    = 3'd3,
		KIND_EOF    = 3'd4
	} token_kind_t;

	typedef enum logic [3:0] {
		MODE_GROUND   = 4'd0,
		MODE_COMMENT  = 4'd1,
		MODE_DQ_EMPTY = 4'd2,
		MODE_DQ       = 4'd3,
		MODE_SQ_EMPTY = 4'd4,
		MODE_SQ       = 4'd5,
		MODE_ESCAPE   = 4'd6,
		MODE_IHELD    = 4'd7,
		MODE_ISKIP    = 4'd8,
		MODE_NUMBER   = 4'd9,
		MODE_WORD     = 4'd10
	} lex_mode_t;

	typedef struct packed {
		token_kind_t kind;
		logic [7:0]  text;
		logic        has;
		logic        first;
		logic        tok_end;
	} tok_res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SLASH) || (c == CH_STAR) ||
			(c == CH_PERCENT) || (c == CH_AMP) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
			(c == CH_GT) || (c == CH_LT) || (c == CH_CARET) || (c == CH_PIPE) ||
			(c == CH_EQUAL) || (c == CH_BANG) || (c == CH_COLON);
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || is_op(c);
	endfunction

endpackage

FILE: src/stt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer channels
// Valid/ready channels for source bytes and for token results.
// ----------------------------------------------------------------------------
interface stt_byte_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] source_byte;

	modport source (output valid, action, source_byte, input ready);
	modport sink (input valid, action, source_byte, output ready);
endinterface

interface stt_token_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] text_byte;
	logic       has_byte;
	logic       token_first;
	logic       token_end;
	logic       last;

	modport source (output valid, token_kind, text_byte, has_byte, token_first, token_end,
		last, input ready);
	modport sink (input valid, token_kind, text_byte, has_byte, token_first, token_end,
		last, output ready);
endinterface

FILE: src/source_text_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer
// Turns a stream of source bytes into string, operator, word, end-of-line
// and end-of-file token results.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  chars    in   action, source_byte
//  tokens   out  token_kind, text_byte, has_byte, token_first, token_end, last
//
//  A request is scanned in the cycle it is accepted; its results (up to four)
//  are loaded into a result group register and leave one per cycle while
//  tokens.ready is high. A request that causes one result or none sustains one
//  request per cycle while tokens.ready is high; one causing more results holds the output until its last is taken.
//  A new request is taken while the last result of the previous one is taken.
//  Reset returns the scanner to ground mode and empties the result group.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top
	import stt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	stt_byte_if.sink           chars,
	stt_token_if.source        tokens
);

	localparam int IDX_W = $clog2(MAX_RES);
	localparam int CNT_W = $clog2(MAX_RES + 1);

	lex_mode_t        mode_q;
	logic             eol_pending_q;
	logic             any_seen_q;

	tok_res_t         grp_q [MAX_RES];
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;

	tok_res_t         res_d [MAX_RES];
	logic [CNT_W-1:0] cnt_d;
	lex_mode_t        mode_d;
	logic             eol_d;
	logic             seen_d;
	logic             do_ground;

	logic             in_fire;
	logic             out_fire;
	logic             at_last;
	logic [7:0]       c;

	assign c        = chars.source_byte;
	assign at_last  = ({1'b0, idx_q} == CNT_W'(cnt_q - CNT_W'(1)));
	assign out_fire = tokens.valid && tokens.ready;
	assign in_fire  = chars.valid && chars.ready;

	assign chars.ready = (cnt_q == '0) || (tokens.ready && at_last);

	// Scanning step: results and next state for the byte at the input.
	always_comb begin
		for (int k = 0; k < MAX_RES; k++) begin
			res_d[k] = '{KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0};
		end
		cnt_d     = '0;
		mode_d    = mode_q;
		eol_d     = eol_pending_q;
		seen_d    = any_seen_q;
		do_ground = 1'b0;

		if (chars.action) begin
			unique case (mode_q)
				MODE_NUMBER, MODE_WORD: begin
					res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, 8'h00, 1'b0, 1'b0, 1'b1};
					cnt_d = cnt_d + CNT_W'(1);
				end
				MODE_IHELD: begin
					if (eol_d) begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_EOL, 8'h00, 1'b0, 1'b1, 1'b1};
						cnt_d = cnt_d + CNT_W'(1);
					end
					res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, CH_I, 1'b1, 1'b1, 1'b1};
					cnt_d = cnt_d + CNT_W'(1);
				end
				MODE_DQ_EMPTY, MODE_SQ_EMPTY: begin
					res_d[cnt_d[IDX_W-1:0]] = '{KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1};
					cnt_d = cnt_d + CNT_W'(1);
				end
				MODE_DQ, MODE_SQ: begin
					res_d[cnt_d[IDX_W-1:0]] = '{KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1};
					cnt_d = cnt_d + CNT_W'(1);
				end
				default: begin
				end
			endcase
			res_d[cnt_d[IDX_W-1:0]] = '{KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1};
			cnt_d  = cnt_d + CNT_W'(1);
			mode_d = MODE_GROUND;
			eol_d  = 1'b0;
			seen_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (c == CH_NL) mode_d = MODE_GROUND;
				end
				MODE_DQ_EMPTY, MODE_DQ, MODE_SQ_EMPTY, MODE_SQ: begin
					if (((mode_q == MODE_DQ_EMPTY || mode_q == MODE_DQ) && c == CH_DQUOTE) ||
						((mode_q == MODE_SQ_EMPTY || mode_q == MODE_SQ) && c == CH_SQUOTE)) begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_STRING, 8'h00, 1'b0,
							(mode_q == MODE_DQ_EMPTY || mode_q == MODE_SQ_EMPTY), 1'b1};
						mode_d = MODE_GROUND;
					end else begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_STRING, c, 1'b1,
							(mode_q == MODE_DQ_EMPTY || mode_q == MODE_SQ_EMPTY), 1'b0};
						mode_d = (mode_q == MODE_DQ_EMPTY || mode_q == MODE_DQ) ?
							MODE_DQ : MODE_SQ;
					end
					cnt_d = cnt_d + CNT_W'(1);
				end
				MODE_ESCAPE: begin
					mode_d = MODE_GROUND;
				end
				MODE_IHELD: begin
					if (is_digit(c)) begin
						mode_d = MODE_ISKIP;
					end else begin
						if (eol_d) begin
							res_d[cnt_d[IDX_W-1:0]] = '{KIND_EOL, 8'h00, 1'b0, 1'b1, 1'b1};
							cnt_d = cnt_d + CNT_W'(1);
						end
						eol_d  = 1'b0;
						seen_d = 1'b1;
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, CH_I, 1'b1, 1'b1, 1'b0};
						cnt_d = cnt_d + CNT_W'(1);
						if (is_delim(c)) begin
							res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, 8'h00, 1'b0, 1'b0, 1'b1};
							cnt_d     = cnt_d + CNT_W'(1);
							do_ground = 1'b1;
						end else begin
							res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, c, 1'b1, 1'b0, 1'b0};
							cnt_d  = cnt_d + CNT_W'(1);
							mode_d = MODE_WORD;
						end
					end
				end
				MODE_ISKIP: begin
					if (c == CH_SPACE) mode_d = MODE_GROUND;
				end
				MODE_NUMBER, MODE_WORD: begin
					if ((mode_q == MODE_NUMBER) ? (c == CH_DOT || is_digit(c)) : !is_delim(c)) begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, c, 1'b1, 1'b0, 1'b0};
					end else begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, 8'h00, 1'b0, 1'b0, 1'b1};
						do_ground = 1'b1;
					end
					cnt_d = cnt_d + CNT_W'(1);
				end
				default: begin
					do_ground = 1'b1;
				end
			endcase

			if (do_ground) begin
				mode_d = MODE_GROUND;
				priority if (c == CH_HASH) begin
					mode_d = MODE_COMMENT;
				end else if (c == CH_NL) begin
					if (seen_d) eol_d = 1'b1;
				end else if (c == CH_BSLASH) begin
					mode_d = MODE_ESCAPE;
				end else if (c == CH_SPACE || c == CH_TAB) begin
					mode_d = MODE_GROUND;
				end else if (c == CH_I) begin
					mode_d = MODE_IHELD;
				end else begin
					// Every other byte starts a token, so a held end of line goes first.
					if (eol_d) begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_EOL, 8'h00, 1'b0, 1'b1, 1'b1};
						cnt_d = cnt_d + CNT_W'(1);
					end
					eol_d  = 1'b0;
					seen_d = 1'b1;
					priority if (c == CH_DQUOTE) begin
						mode_d = MODE_DQ_EMPTY;
					end else if (c == CH_SQUOTE) begin
						mode_d = MODE_SQ_EMPTY;
					end else if (is_op(c)) begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_OPER, c, 1'b1, 1'b1, 1'b1};
						cnt_d = cnt_d + CNT_W'(1);
					end else begin
						res_d[cnt_d[IDX_W-1:0]] = '{KIND_WORD, c, 1'b1, 1'b1, 1'b0};
						cnt_d  = cnt_d + CNT_W'(1);
						mode_d = (c == CH_DOT || is_digit(c)) ? MODE_NUMBER : MODE_WORD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_GROUND;
			eol_pending_q <= 1'b0;
			any_seen_q    <= 1'b0;
		end else if (in_fire) begin
			mode_q        <= mode_d;
			eol_pending_q <= eol_d;
			any_seen_q    <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (in_fire) begin
			cnt_q <= cnt_d;
			idx_q <= '0;
		end else if (out_fire) begin
			if (at_last) begin
				cnt_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int k = 0; k < MAX_RES; k++) begin
				grp_q[k] <= res_d[k];
			end
		end
	end

	assign tokens.valid       = (cnt_q != '0);
	assign tokens.token_kind  = grp_q[idx_q].kind;
	assign tokens.text_byte   = grp_q[idx_q].text;
	assign tokens.has_byte    = grp_q[idx_q].has;
	assign tokens.token_first = grp_q[idx_q].first;
	assign tokens.token_end   = grp_q[idx_q].tok_end;
	assign tokens.last        = at_last;

endmodule
